>>> design/cdq_pkg.sv
package cdq_pkg;

	// Storage and field widths
	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;
	localparam int OP_W   = 3;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_NONE       = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_REAR  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_REAR   = 3'd4
	} op_t;

	// Row-wide moves, issued by the control to every cell
	typedef struct packed {
		logic             shr;      // all cells take the left neighbor
		logic             shl;      // all cells take the right neighbor
		logic             wr_rear;  // one cell loads the pushed word
		logic [IDX_W-1:0] wr_idx;   // which cell loads on a rear push
	} row_ctl_t;

	// Per-cell move select
	typedef struct packed {
		logic load;
		logic shr;
		logic shl;
	} cell_ctl_t;

	// Status of the item just taken, as it stands after the operation
	typedef struct packed {
		logic             ok;
		logic             empty;
		logic             full;
		logic [IDX_W-1:0] rear_idx;
	} op_res_t;

endpackage

>>> design/cdq_cell.sv
module cdq_cell (
	input  logic                          clk,
	input  cdq_pkg::cell_ctl_t            ctl,
	input  logic [cdq_pkg::DATA_W-1:0]    load_val,
	input  logic [cdq_pkg::DATA_W-1:0]    left,
	input  logic [cdq_pkg::DATA_W-1:0]    right,
	output logic [cdq_pkg::DATA_W-1:0]    data,
	output logic [cdq_pkg::DATA_W-1:0]    data_next
);

	logic [cdq_pkg::DATA_W-1:0] data_q;

	// Next word: a direct load wins, else follow the row shift
	always_comb begin
		priority if (ctl.load) begin
			data_next = load_val;
		end else if (ctl.shr) begin
			data_next = left;
		end else if (ctl.shl) begin
			data_next = right;
		end else begin
			data_next = data_q;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data = data_q;

endmodule

>>> design/cdq_ctrl.sv
module cdq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [cdq_pkg::OP_W-1:0]      opcode,
	input  logic                          cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]     cfg_data,
	output cdq_pkg::row_ctl_t             row_ctl,
	output cdq_pkg::op_res_t              res
);

	localparam logic [cdq_pkg::CAP_W-1:0] DEPTH_CAP = cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
	localparam logic [cdq_pkg::CNT_W-1:0] CNT_ONE   = cdq_pkg::CNT_W'(1);

	logic [cdq_pkg::CAP_W-1:0] cap_q;
	logic [cdq_pkg::CNT_W-1:0] count_q;
	logic [cdq_pkg::CNT_W-1:0] count_next;
	logic [cdq_pkg::CNT_W-1:0] cap_eff;
	logic                      full_now;
	logic                      empty_now;
	logic                      ok;
	cdq_pkg::op_t              op;

	// Clamp capacity into 1..DEPTH
	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = cdq_pkg::CNT_W'(1);
		end else if (cap_q > DEPTH_CAP) begin
			cap_eff = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
		end else begin
			cap_eff = cdq_pkg::CNT_W'(cap_q);
		end
	end

	assign full_now  = (count_q >= cap_eff);
	assign empty_now = (count_q == '0);
	assign op        = cdq_pkg::op_t'(opcode);

	// Decode the operation into row moves and the new fill count
	always_comb begin
		row_ctl    = '0;
		row_ctl.wr_idx = count_q[cdq_pkg::IDX_W-1:0];
		count_next = count_q;
		ok         = 1'b0;
		unique case (op)
			cdq_pkg::OP_NONE: begin
				ok = 1'b1;
			end
			cdq_pkg::OP_PUSH_FRONT: begin
				if (!full_now) begin
					row_ctl.shr = go;
					count_next  = count_q + CNT_ONE;
					ok          = 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_REAR: begin
				if (!full_now) begin
					row_ctl.wr_rear = go;
					count_next      = count_q + CNT_ONE;
					ok              = 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (!empty_now) begin
					row_ctl.shl = go;
					count_next  = count_q - CNT_ONE;
					ok          = 1'b1;
				end
			end
			cdq_pkg::OP_POP_REAR: begin
				if (!empty_now) begin
					count_next = count_q - CNT_ONE;
					ok         = 1'b1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Status after the operation; rear sits at cell count-1
	always_comb begin
		res.ok       = ok;
		res.empty    = (count_next == '0);
		res.full     = (count_next == cap_eff);
		res.rear_idx = cdq_pkg::IDX_W'(count_next - CNT_ONE);
	end

	// Capacity write also empties the deque
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= cdq_pkg::CAP_W'(16);
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_data;
			count_q <= '0;
		end else if (go) begin
			count_q <= count_next;
		end
	end

endmodule

>>> design/circular_deque_unit.sv
// An item that is taken shows its result, with done high, in the following cycle.
// Throughput: one item per cycle while no capacity write is offered; the row of cells shifts or loads in a single step.
// busy is high only while a capacity write is offered; that write empties the deque.
// Reset clears the fill count and sets capacity to 16; stored words are not cleared.
// The receiver cannot stall: each result stands for exactly one cycle.
module circular_deque_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cdq_pkg::OP_W-1:0]      opcode,
	input  logic signed [cdq_pkg::DATA_W-1:0] value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]     cfg_data,
	output logic                          done,
	output logic                          success,
	output logic signed [cdq_pkg::DATA_W-1:0] front_value,
	output logic signed [cdq_pkg::DATA_W-1:0] rear_value,
	output logic                          is_empty,
	output logic                          is_full
);

	logic                        go;
	cdq_pkg::row_ctl_t           row_ctl;
	cdq_pkg::op_res_t            res;
	logic [cdq_pkg::DATA_W-1:0]  cell_q    [cdq_pkg::DEPTH];
	logic [cdq_pkg::DATA_W-1:0]  cell_next [cdq_pkg::DEPTH];

	logic                        done_q;
	logic                        success_q;
	logic [cdq_pkg::DATA_W-1:0]  front_q;
	logic [cdq_pkg::DATA_W-1:0]  rear_q;
	logic                        empty_q;
	logic                        full_q;

	// Configuration write takes the cycle
	assign cfg_ready = 1'b1;
	assign busy      = cfg_valid;
	assign go        = start & ~busy;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.opcode   (opcode),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.row_ctl  (row_ctl),
		.res      (res)
	);

	// Row of cells: cell 0 holds the front, each cell talks to its neighbors
	for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
		cdq_pkg::cell_ctl_t          cctl;
		logic [cdq_pkg::DATA_W-1:0]  left_w;
		logic [cdq_pkg::DATA_W-1:0]  right_w;

		assign cctl.load = row_ctl.wr_rear && (row_ctl.wr_idx == cdq_pkg::IDX_W'(i));
		assign cctl.shr  = row_ctl.shr;
		assign cctl.shl  = row_ctl.shl;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end

		if (i == cdq_pkg::DEPTH - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		cdq_cell u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.load_val  (value),
			.left      (left_w),
			.right     (right_w),
			.data      (cell_q[i]),
			.data_next (cell_next[i])
		);
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go;
		end
	end

	// Result payload, taken from the row as it will stand after the operation
	always_ff @(posedge clk) begin
		if (go) begin
			success_q <= res.ok;
			empty_q   <= res.empty;
			full_q    <= res.full;
			if (res.empty) begin
				front_q <= '1;
				rear_q  <= '1;
			end else begin
				front_q <= cell_next[0];
				rear_q  <= cell_next[res.rear_idx];
			end
		end
	end

	assign done        = done_q;
	assign success     = success_q;
	assign front_value = front_q;
	assign rear_value  = rear_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

endmodule

>>> design/cdq_checker.sv
module cdq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [cdq_pkg::OP_W-1:0]          opcode,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic                              done,
	input logic                              success,
	input logic signed [cdq_pkg::DATA_W-1:0] front_value,
	input logic signed [cdq_pkg::DATA_W-1:0] rear_value,
	input logic                              is_empty,
	input logic                              is_full
);

	// Every taken item gives a result in the next cycle
	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("taken item gave no result");

	// No result without an item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an item");

	// Capacity is at least one, so empty and full never coincide
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty && is_full))
		else $error("empty and full together");

	// An empty deque shows all ones on both ends
	a_empty_vals: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (front_value == -32'sd1 && rear_value == -32'sd1))
		else $error("empty deque shows a value");

	// A capacity write leaves the deque empty, so a following pop fails
	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) ##1
		(start && !busy && opcode == cdq_pkg::OP_POP_FRONT) |=> !success)
		else $error("pop succeeded right after a capacity write");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// Opcodes that the block does not define; they must come back with success low
localparam logic [cdq_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
localparam logic [cdq_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

// Word reported for front and rear while the deque holds nothing
localparam logic [cdq_pkg::DATA_W-1:0] NO_ENTRY = '1;

typedef struct {
	logic                      ok;
	logic [cdq_pkg::DATA_W-1:0] front;
	logic [cdq_pkg::DATA_W-1:0] rear;
	logic                      empty;
	logic                      full;
} deque_status_t;

// Deque predictor plus the queue of statuses still due from the block
class deque_scoreboard;
	logic [cdq_pkg::DATA_W-1:0] ring[cdq_pkg::DEPTH];
	int head;
	int fill;
	int cap_reg;
	deque_status_t due_q[$];
	int errors;
	int items_seen;
	int results_checked;
	int cap_writes;

	function new();
		head = 0;
		fill = 0;
		cap_reg = 16;
	endfunction

	// Register value clamped to 1..DEPTH
	function int live_cap();
		int c;
		c = cap_reg;
		if (c < 1)
			c = 1;
		if (c > cdq_pkg::DEPTH)
			c = cdq_pkg::DEPTH;
		return c;
	endfunction

	function int wrap(int a, int b, int c);
		int s;
		s = a + b;
		if (s >= c)
			s -= c;
		return s;
	endfunction

	function int pending();
		return due_q.size();
	endfunction

	// A capacity write also empties the deque; stored words stay but are hidden
	function void write_capacity(logic [cdq_pkg::CAP_W-1:0] v);
		cap_reg = int'(v);
		head = 0;
		fill = 0;
		cap_writes++;
	endfunction

	// Apply one accepted item and queue the status it should produce
	function void note_item(logic [cdq_pkg::OP_W-1:0] op, logic [cdq_pkg::DATA_W-1:0] v);
		deque_status_t st;
		int c;
		bit was_full;
		bit was_empty;
		c = live_cap();
		was_full = fill >= c;
		was_empty = fill == 0;
		st.ok = 1'b0;
		case (op)
			cdq_pkg::OP_NONE: st.ok = 1'b1;
			cdq_pkg::OP_PUSH_FRONT: begin
				if (!was_full) begin
					// first entry lands on the head without moving it
					if (!was_empty)
						head = (head == 0) ? c - 1 : head - 1;
					ring[head] = v;
					fill++;
					st.ok = 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_REAR: begin
				if (!was_full) begin
					ring[wrap(head, fill, c)] = v;
					fill++;
					st.ok = 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (!was_empty) begin
					head = wrap(head, 1, c);
					fill--;
					st.ok = 1'b1;
				end
			end
			cdq_pkg::OP_POP_REAR: begin
				if (!was_empty) begin
					fill--;
					st.ok = 1'b1;
				end
			end
			default: ;
		endcase
		st.empty = fill == 0;
		st.full = fill == c;
		if (st.empty) begin
			st.front = NO_ENTRY;
			st.rear = NO_ENTRY;
		end else begin
			st.front = ring[head];
			st.rear = ring[wrap(head, fill - 1, c)];
		end
		due_q.push_back(st);
		items_seen++;
	endfunction

	function void cmp_field(string name, logic [cdq_pkg::DATA_W-1:0] e,
		logic [cdq_pkg::DATA_W-1:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %h, got %h", $time, name, e, a);
			errors++;
		end
	endfunction

	function void cmp_bit(string name, logic e, logic a);
		if (e !== a) begin
			$display("%0t: %s expected %b, got %b", $time, name, e, a);
			errors++;
		end
	endfunction

	// Compare one strobed result against the oldest due status
	function void check(deque_status_t got);
		deque_status_t e;
		if (due_q.size() == 0) begin
			$display("%0t: result with none due: expected nothing, got ok=%b front=%h rear=%h",
				$time, got.ok, got.front, got.rear);
			errors++;
			return;
		end
		e = due_q.pop_front();
		cmp_bit("success", e.ok, got.ok);
		cmp_field("front_value", e.front, got.front);
		cmp_field("rear_value", e.rear, got.rear);
		cmp_bit("is_empty", e.empty, got.empty);
		cmp_bit("is_full", e.full, got.full);
		results_checked++;
	endfunction
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [cdq_pkg::OP_W-1:0] opcode = '0;
	logic signed [cdq_pkg::DATA_W-1:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cdq_pkg::CAP_W-1:0] cfg_data = '0;
	logic done;
	logic success;
	logic signed [cdq_pkg::DATA_W-1:0] front_value;
	logic signed [cdq_pkg::DATA_W-1:0] rear_value;
	logic is_empty;
	logic is_full;

	deque_scoreboard sb = new();
	int idle_pct = 0;

	circular_deque_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.success(success),
		.front_value(front_value),
		.rear_value(rear_value),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watch handshakes: results first, then newly accepted items and writes
	always @(posedge clk) begin
		deque_status_t got;
		if (arst_n) begin
			if (done) begin
				got.ok = success;
				got.front = front_value;
				got.rear = rear_value;
				got.empty = is_empty;
				got.full = is_full;
				sb.check(got);
			end
			if (start && !busy)
				sb.note_item(opcode, value);
			if (cfg_valid && cfg_ready)
				sb.write_capacity(cfg_data);
		end
	end

	// Offer one item after a random idle stretch; return at the accepting edge
	task automatic send_item(input logic [cdq_pkg::OP_W-1:0] op,
		input logic [cdq_pkg::DATA_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			opcode <= cdq_pkg::OP_W'($urandom);
			value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Capacity write once every due result is back
	task automatic set_capacity(input logic [cdq_pkg::CAP_W-1:0] v);
		start <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [cdq_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Random traffic that alternates between filling and draining runs
	task automatic run_phase(input logic [cdq_pkg::CAP_W-1:0] cap, input int pct, input int n);
		bit filling;
		int run_left;
		int r;
		logic [cdq_pkg::OP_W-1:0] op;
		set_capacity(cap);
		idle_pct = pct;
		filling = 1'b1;
		run_left = $urandom_range(40, 4);
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				filling = !filling;
				run_left = $urandom_range(40, 4);
			end
			run_left--;
			r = $urandom_range(99);
			if (r >= 95)
				op = cdq_pkg::OP_W'($urandom_range(OP_RSVD7, OP_RSVD5));
			else if (r >= 90)
				op = cdq_pkg::OP_NONE;
			else if (filling)
				op = (r < 35) ? cdq_pkg::OP_PUSH_FRONT : (r < 70) ? cdq_pkg::OP_PUSH_REAR :
					(r < 80) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
			else
				op = (r < 10) ? cdq_pkg::OP_PUSH_FRONT : (r < 20) ? cdq_pkg::OP_PUSH_REAR :
					(r < 55) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
			send_item(op, pick_word());
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, no-op, reserved codes, extreme words at full depth
		send_item(cdq_pkg::OP_POP_FRONT, '0);
		send_item(cdq_pkg::OP_POP_REAR, '0);
		send_item(cdq_pkg::OP_NONE, '1);
		for (int c = OP_RSVD5; c <= OP_RSVD7; c++)
			send_item(cdq_pkg::OP_W'(c), $urandom);
		send_item(cdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_item(cdq_pkg::OP_PUSH_REAR, 32'h8000_0000);
		send_item(cdq_pkg::OP_PUSH_FRONT, '0);
		send_item(cdq_pkg::OP_PUSH_REAR, '1);
		send_item(cdq_pkg::OP_POP_FRONT, '0);
		send_item(cdq_pkg::OP_POP_REAR, '0);

		// Capacity two: front push wraps the head, then full and drained
		set_capacity(5'd2);
		send_item(cdq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
		send_item(cdq_pkg::OP_PUSH_FRONT, 32'hCAFE_0001);
		send_item(cdq_pkg::OP_PUSH_REAR, 32'h5555_AAAA);
		send_item(cdq_pkg::OP_NONE, '0);
		send_item(cdq_pkg::OP_POP_REAR, '0);
		send_item(cdq_pkg::OP_POP_FRONT, '0);

		// Capacity one: every push fills it
		set_capacity(5'd1);
		send_item(cdq_pkg::OP_PUSH_REAR, 32'hAAAA_5555);
		send_item(cdq_pkg::OP_PUSH_FRONT, 32'h0F0F_0F0F);
		send_item(cdq_pkg::OP_POP_FRONT, '0);
		send_item(cdq_pkg::OP_PUSH_FRONT, 32'hF0F0_F0F0);
		send_item(cdq_pkg::OP_POP_REAR, '0);

		// Random phases over capacities, including zero and above the depth
		run_phase(5'd1, 0, 95);
		run_phase(5'd0, 79, 95);
		run_phase(5'd2, 36, 95);
		run_phase(5'd16, 0, 95);
		run_phase(5'd31, 79, 95);
		run_phase(5'd17, 36, 95);
		run_phase(cdq_pkg::CAP_W'($urandom_range(15, 3)), 0, 95);
		run_phase(cdq_pkg::CAP_W'($urandom_range(31, 0)), 79, 95);
		run_phase(5'd3, 36, 95);
		run_phase(5'd16, 0, 95);
		start <= 1'b0;

		// Drain, then a short quiet tail
		wait_cycles = 0;
		while (sb.pending() > 0 && wait_cycles < 100) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (5) @(posedge clk);
		if (sb.pending() > 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors++;
		end

		$display("Sent %0d items, checked %0d results, %0d capacity writes",
			sb.items_seen, sb.results_checked, sb.cap_writes);
		$display("Capacities included zero and values past the depth; idle 0, 36, 79 percent");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#400_000;
		$display("Timeout at %0t", $time);
		$display("Mismatches found");
		$finish;
	end
endmodule
